>>> hdl/htlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_pkg
// Shared types and constants for the linear-probe hash table engine.
// ----------------------------------------------------------------------------
package htlp_pkg;

  localparam int HtlpCapacity   = 256;
  localparam int HtlpKeyBytes   = 8;
  localparam int HtlpValueBytes = 8;

  localparam logic [0:0] CmdSet = 1'b0;
  localparam logic [0:0] CmdGet = 1'b1;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StUpdated  = 3'd1;
  localparam logic [2:0] StFound    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  localparam logic [63:0] HashSeed = 64'd5381;
  localparam int          HashShift = 5;

  typedef struct packed {
    logic [0:0]  command;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [63:0] value_bytes;
    logic [3:0]  value_length;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_value;
    logic [3:0]  found_length;
    logic [7:0]  slot;
    logic [8:0]  entries_in_use;
  } out_t;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_BYTE,
    HS_MOD
  } hash_state_e;

  typedef enum logic [2:0] {
    TS_CLEAR,
    TS_IDLE,
    TS_HASH,
    TS_READ,
    TS_CHECK,
    TS_RESP
  } top_state_e;

endpackage

>>> hdl/htlp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module htlp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/htlp_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_hash
// Byte-serial 64-bit djb2 hash, then reduction modulo capacity: the low bits for a
// power-of-two capacity, else a reciprocal estimate with subtract and correct.
module htlp_hash #(
  parameter int Capacity = htlp_pkg::HtlpCapacity,
  parameter int KeyBytes = htlp_pkg::HtlpKeyBytes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [KeyBytes*8-1:0]       key_i,
  input  logic [3:0]                  len_i,
  output logic                        done_o,
  output logic [$clog2(Capacity)-1:0] home_o
);
  import htlp_pkg::*;

  localparam int AW = $clog2(Capacity);
  localparam int KW = KeyBytes * 8;
  localparam bit IsPow2 = (Capacity == (1 << AW));
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / Capacity);
  localparam logic [31:0] CapW  = 32'(Capacity);

  hash_state_e   state_q, state_d;
  logic [63:0]   h_q, h_d;
  logic [3:0]    idx_q, idx_d;
  logic [3:0]    len_q, len_d;
  logic [KW-1:0] key_q, key_d;
  logic [1:0]    dig_q, dig_d;
  logic          ph_q, ph_d;
  logic [31:0]   q_q, q_d;
  logic [AW-1:0] rem_q, rem_d;
  logic [7:0]    byte_v;
  logic [15:0]   digit_v;
  logic [31:0]   x_v;
  logic [63:0]   mul_v;
  logic [31:0]   qc_v;
  logic [31:0]   r_v;
  logic [31:0]   rfix_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    idx_q <= idx_d;
    len_q <= len_d;
    key_q <= key_d;
    dig_q <= dig_d;
    ph_q  <= ph_d;
    q_q   <= q_d;
    rem_q <= rem_d;
  end

  always_comb begin
    byte_v = 8'h00;
    for (int i = 0; i < KeyBytes; i++) begin
      if (idx_q == 4'(i)) begin
        byte_v = key_q[i*8 +: 8];
      end
    end
  end

  // 16 bits of the hash per step: estimate quotient, then subtract and correct
  always_comb begin
    digit_v = h_q[{dig_q, 4'd0} +: 16];
    x_v     = {16'(rem_q), digit_v};
    mul_v   = {32'd0, x_v} * {32'd0, Recip};
    qc_v    = q_q * CapW;
    r_v     = x_v - qc_v;
    rfix_v  = (r_v >= CapW) ? r_v - CapW : r_v;
  end

  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    idx_d   = idx_q;
    len_d   = len_q;
    key_d   = key_q;
    dig_d   = dig_q;
    ph_d    = ph_q;
    q_d     = q_q;
    rem_d   = rem_q;
    done_o  = 1'b0;
    home_o  = IsPow2 ? h_q[AW-1:0] : AW'(rfix_v);
    unique case (state_q)
      HS_IDLE: begin
        if (start_i) begin
          h_d     = HashSeed;
          idx_d   = 4'd0;
          len_d   = len_i;
          key_d   = key_i;
          state_d = HS_BYTE;
        end
      end
      HS_BYTE: begin
        if (idx_q == len_q) begin
          if (IsPow2) begin
            done_o  = 1'b1;
            state_d = HS_IDLE;
          end else begin
            dig_d   = 2'd3;
            ph_d    = 1'b0;
            rem_d   = '0;
            state_d = HS_MOD;
          end
        end else begin
          h_d   = h_q + (h_q << HashShift) + {56'd0, byte_v};
          idx_d = idx_q + 4'd1;
        end
      end
      HS_MOD: begin
        if (!ph_q) begin
          q_d  = mul_v[63:32];
          ph_d = 1'b1;
        end else begin
          rem_d = AW'(rfix_v);
          ph_d  = 1'b0;
          if (dig_q == 2'd0) begin
            done_o  = 1'b1;
            state_d = HS_IDLE;
          end else begin
            dig_d = dig_q - 2'd1;
          end
        end
      end
      default: state_d = HS_IDLE;
    endcase
  end

endmodule

>>> hdl/hash_table_linear_probe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_table_linear_probe
// Open-addressing key-value table with djb2 home slot and linear probing.
// ----------------------------------------------------------------------------
// sequence: input transfer, hash over the key bytes, a modulo step of the 64-bit
//   hash when CAPACITY is not a power of two, then a read and a compare per probe
// throughput: one request at a time; each probe is a read and a compare in the
//   single slot RAM
// reset: a clearing pass writes every slot empty, with in_stall_o high; entry
//   count resets to zero
module hash_table_linear_probe #(
  parameter int CAPACITY    = htlp_pkg::HtlpCapacity,
  parameter int KEY_BYTES   = htlp_pkg::HtlpKeyBytes,
  parameter int VALUE_BYTES = htlp_pkg::HtlpValueBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  htlp_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output htlp_pkg::out_t out_data_o
);
  import htlp_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int KW = KEY_BYTES * 8;
  localparam int VW = VALUE_BYTES * 8;

  typedef struct packed {
    logic          used;
    logic [KW-1:0] key;
    logic [3:0]    klen;
    logic [VW-1:0] val;
    logic [3:0]    vlen;
  } entry_t;

  localparam int EW = $bits(entry_t);

  top_state_e    state_q, state_d;
  logic [0:0]    cmd_q, cmd_d;
  logic [KW-1:0] key_q, key_d;
  logic [3:0]    klen_q, klen_d;
  logic [VW-1:0] val_q, val_d;
  logic [3:0]    vlen_q, vlen_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW:0]   probes_q, probes_d;
  logic [AW:0]   count_q, count_d;
  out_t          res_q, res_d;
  out_t          out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          in_xfer;
  logic [3:0]    klen_sat, vlen_sat;
  logic [KW-1:0] key_m, kmask;
  logic [VW-1:0] val_m, vmask;
  logic          hash_done;
  logic [AW-1:0] hash_home;
  logic          we;
  entry_t        wdata, rdata;
  logic          hit, last;
  logic [AW-1:0] next_addr;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != TS_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // length saturation and byte masking
  always_comb begin
    klen_sat = (in_data_i.key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES)
                                                      : in_data_i.key_length;
    vlen_sat = (in_data_i.value_length > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES)
                                                          : in_data_i.value_length;
    for (int i = 0; i < KEY_BYTES; i++) begin
      kmask[i*8 +: 8] = (4'(i) < klen_sat) ? 8'hff : 8'h00;
    end
    for (int i = 0; i < VALUE_BYTES; i++) begin
      vmask[i*8 +: 8] = (4'(i) < vlen_sat) ? 8'hff : 8'h00;
    end
    key_m = in_data_i.key_bytes[KW-1:0] & kmask;
    val_m = in_data_i.value_bytes[VW-1:0] & vmask;
  end

  htlp_hash #(
    .Capacity (CAPACITY),
    .KeyBytes (KEY_BYTES)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_xfer),
    .key_i   (key_m),
    .len_i   (klen_sat),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  htlp_ram #(
    .Width (EW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TS_CLEAR;
      addr_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    klen_q   <= klen_d;
    val_q    <= val_d;
    vlen_q   <= vlen_d;
    probes_q <= probes_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    klen_d      = klen_q;
    val_d       = val_q;
    vlen_d      = vlen_q;
    addr_d      = addr_q;
    probes_d    = probes_q;
    count_d     = count_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    wdata       = '0;
    hit         = rdata.used && (rdata.klen == klen_q) && (rdata.key == key_q);
    last        = (probes_q == (AW+1)'(CAPACITY - 1));
    next_addr   = (addr_q == AW'(CAPACITY - 1)) ? '0 : addr_q + AW'(1);
    unique case (state_q)
      TS_CLEAR: begin
        we     = 1'b1;
        addr_d = next_addr;
        if (addr_q == AW'(CAPACITY - 1)) begin
          state_d = TS_IDLE;
        end
      end
      TS_IDLE: begin
        if (in_xfer) begin
          cmd_d   = in_data_i.command;
          key_d   = key_m;
          klen_d  = klen_sat;
          val_d   = val_m;
          vlen_d  = vlen_sat;
          state_d = TS_HASH;
        end
      end
      TS_HASH: begin
        if (hash_done) begin
          addr_d   = hash_home;
          probes_d = '0;
          state_d  = TS_READ;
        end
      end
      TS_READ: begin
        state_d = TS_CHECK;
      end
      TS_CHECK: begin
        res_d = '0;
        res_d.entries_in_use = 9'(count_q);
        if (cmd_q == CmdSet) begin
          if (!rdata.used || hit) begin
            we         = 1'b1;
            wdata.used = 1'b1;
            wdata.key  = key_q;
            wdata.klen = klen_q;
            wdata.val  = val_q;
            wdata.vlen = vlen_q;
            res_d.slot = 8'(addr_q);
            if (!rdata.used) begin
              count_d              = count_q + (AW+1)'(1);
              res_d.status         = StInserted;
              res_d.entries_in_use = 9'(count_q + (AW+1)'(1));
            end else begin
              res_d.status = StUpdated;
            end
            state_d = TS_RESP;
          end else if (last) begin
            res_d.status = StFull;
            state_d      = TS_RESP;
          end else begin
            addr_d   = next_addr;
            probes_d = probes_q + (AW+1)'(1);
            state_d  = TS_READ;
          end
        end else begin
          if (hit) begin
            res_d.status       = StFound;
            res_d.found_value  = 64'(rdata.val);
            res_d.found_length = rdata.vlen;
            res_d.slot         = 8'(addr_q);
            state_d            = TS_RESP;
          end else if (!rdata.used || last) begin
            res_d.status = StNotFound;
            state_d      = TS_RESP;
          end else begin
            addr_d   = next_addr;
            probes_d = probes_q + (AW+1)'(1);
            state_d  = TS_READ;
          end
        end
      end
      TS_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = TS_IDLE;
        end
      end
      default: state_d = TS_IDLE;
    endcase
  end

endmodule

>>> hdl/htlp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htlp_checker
// Port-level checks on the hash table engine, bound to the top level.
// ----------------------------------------------------------------------------
module htlp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input htlp_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input htlp_pkg::out_t out_data_o
);
  import htlp_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");

  // a stalled request stays offered
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("request dropped while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StInserted || out_data_o.status == StUpdated ||
                     out_data_o.status == StFound || out_data_o.status == StNotFound ||
                     out_data_o.status == StFull))
    else $error("bad status code");

  a_value_only_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StFound |->
      out_data_o.found_length == 4'd0 && out_data_o.found_value == 64'd0)
    else $error("value returned without a hit");

  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StNotFound || out_data_o.status == StFull) |->
      out_data_o.slot == 8'd0)
    else $error("slot reported on a miss");

endmodule

bind hash_table_linear_probe htlp_checker u_htlp_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear-probe hash table: set/get traffic with
// random gaps and stalls, checked against an in-bench table predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import htlp_pkg::*;

  localparam int Cap = HtlpCapacity;
  localparam int LimitCycles = 4000000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  hash_table_linear_probe i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // table predictor state
  bit          tbl_used [Cap];
  logic [63:0] tbl_key  [Cap];
  logic [3:0]  tbl_klen [Cap];
  logic [63:0] tbl_val  [Cap];
  logic [3:0]  tbl_vlen [Cap];
  int          tbl_count;

  in_t  request_q [$];
  out_t expected_q [$];
  int   mismatches;
  int   cycles;
  int   sent;
  int   got;
  int   n_full;
  int   n_found;
  bit   stim_done;
  bit   hold_rx;
  bit   pause_tx;

  function automatic logic [63:0] mask_bytes(logic [63:0] v, int n);
    logic [63:0] m;
    m = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    return v & m;
  endfunction

  function automatic out_t table_lookup(in_t req);
    out_t        r;
    int          kl;
    int          vl;
    logic [63:0] k;
    logic [63:0] v;
    logic [63:0] h;
    int          p;
    kl = (req.key_length > HtlpKeyBytes) ? HtlpKeyBytes : req.key_length;
    vl = (req.value_length > HtlpValueBytes) ? HtlpValueBytes : req.value_length;
    k = mask_bytes(req.key_bytes, kl);
    v = mask_bytes(req.value_bytes, vl);
    h = HashSeed;
    for (int i = 0; i < kl; i++) h = (h << HashShift) + h + 64'(k[8*i +: 8]);
    r = '0;
    if (req.command == CmdSet) begin
      r.status = StFull;
      for (int i = 0; i < Cap; i++) begin
        p = int'((h % 64'(Cap) + 64'(i)) % 64'(Cap));
        if (!tbl_used[p] || (tbl_klen[p] == 4'(kl) && tbl_key[p] == k)) begin
          if (!tbl_used[p]) begin
            tbl_used[p] = 1;
            tbl_key[p] = k;
            tbl_klen[p] = 4'(kl);
            tbl_count++;
            r.status = StInserted;
          end else begin
            r.status = StUpdated;
          end
          tbl_val[p] = v;
          tbl_vlen[p] = 4'(vl);
          r.slot = 8'(p);
          break;
        end
      end
    end else begin
      r.status = StNotFound;
      for (int i = 0; i < Cap; i++) begin
        p = int'((h % 64'(Cap) + 64'(i)) % 64'(Cap));
        if (!tbl_used[p]) break;
        if (tbl_klen[p] == 4'(kl) && tbl_key[p] == k) begin
          r.status = StFound;
          r.found_value = tbl_val[p];
          r.found_length = tbl_vlen[p];
          r.slot = 8'(p);
          break;
        end
      end
    end
    r.entries_in_use = 9'(tbl_count);
    return r;
  endfunction

  function automatic in_t make_req(logic [0:0] cmd, logic [63:0] k, int kl,
                                   logic [63:0] v, int vl);
    in_t r;
    r.command = cmd;
    r.key_bytes = k;
    r.key_length = 4'(kl);
    r.value_bytes = v;
    r.value_length = 4'(vl);
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
  end

  // driver
  int tx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      in_data_i <= '0;
      tx_gap <= 0;
      sent <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(table_lookup(in_data_i));
        sent <= sent + 1;
      end
      if (in_valid_i && in_stall_o) begin
        // hold payload
      end else if (tx_gap > 0) begin
        in_valid_i <= 0;
        tx_gap <= tx_gap - 1;
      end else if (request_q.size() > 0 && !pause_tx) begin
        in_valid_i <= 1;
        in_data_i <= request_q.pop_front();
        tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else begin
        in_valid_i <= 0;
      end
    end
  end

  // monitor and receiver stall
  int rx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    int   g;
    if (!rst_ni) begin
      out_stall_i <= 0;
      rx_gap <= 0;
      got <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got <= got + 1;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer %p", out_data_o);
        end else begin
          e = expected_q.pop_front();
          if (e.status == StFull) n_full++;
          if (e.status == StFound) n_found++;
          if (out_data_o !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %p got %p", e, out_data_o);
          end
        end
        g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
        rx_gap <= (g > 0) ? g - 1 : 0;
        out_stall_i <= hold_rx || (g > 0);
      end else if (hold_rx) out_stall_i <= 1;
      else if (rx_gap > 0) begin
        out_stall_i <= 1;
        rx_gap <= rx_gap - 1;
      end else out_stall_i <= 0;
    end
  end

  // long receiver hold-off
  initial begin
    hold_rx = 0;
    wait (sent >= 300);
    @(posedge clk_i);
    hold_rx <= 1;
    repeat (400) @(posedge clk_i);
    hold_rx <= 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("timeout");
      $display("[hash_table_linear_probe] ERROR");
      $finish;
    end
  end

  task automatic fill_random(int n, int nkeys);
    logic [63:0] pool [32];
    int          kl;
    for (int i = 0; i < 32; i++) pool[i] = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      kl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      request_q.push_back(make_req(1'($urandom_range(0, 1)),
        ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                    : pool[$urandom_range(0, nkeys - 1)],
        kl, {$urandom, $urandom}, $urandom_range(0, 15)));
    end
  endtask

  initial begin
    mismatches = 0;
    cycles = 0;
    n_full = 0;
    n_found = 0;
    pause_tx = 0;
    stim_done = 0;
    for (int i = 0; i < Cap; i++) tbl_used[i] = 0;
    tbl_count = 0;
    // directed: empty key, extremes, long lengths, update and misses
    request_q.push_back(make_req(CmdGet, '1, 0, '0, 0));
    request_q.push_back(make_req(CmdSet, '1, 0, '1, 8));
    request_q.push_back(make_req(CmdGet, 64'h55, 0, '0, 0));
    request_q.push_back(make_req(CmdSet, '1, 15, '1, 15));
    request_q.push_back(make_req(CmdGet, '1, 8, '0, 0));
    request_q.push_back(make_req(CmdSet, '0, 8, '0, 0));
    request_q.push_back(make_req(CmdSet, '0, 8, 64'h1234, 9));
    request_q.push_back(make_req(CmdGet, '0, 8, '1, 15));
    request_q.push_back(make_req(CmdSet, 64'hAA, 1, 64'hDEAD_BEEF, 3));
    request_q.push_back(make_req(CmdGet, 64'hFFAA, 1, '0, 0));
    request_q.push_back(make_req(CmdGet, 64'hAA, 2, '0, 0));
    request_q.push_back(make_req(CmdSet, 64'hAA, 1, '1, 1));
    request_q.push_back(make_req(CmdGet, 64'hAA, 1, '0, 0));
    fill_random(250, 32);
    wait (request_q.size() == 0 && in_valid_i == 0);
    // sender pause until everything drained
    pause_tx = 1;
    wait (expected_q.size() == 0);
    pause_tx = 0;
    // fill the table to full, then probe a full table
    for (int i = 0; i < Cap + 20; i++)
      request_q.push_back(make_req(CmdSet, {$urandom, $urandom}, 8, {$urandom, $urandom},
                                   $urandom_range(0, 8)));
    fill_random(700, 32);
    wait (request_q.size() == 0 && in_valid_i == 0);
    stim_done = 1;
    wait (expected_q.size() == 0);
    repeat (2000) begin
      @(posedge clk_i);
    end
    $display("run: %0d requests, %0d results, %0d hits, %0d table-full replies",
             sent, got, n_found, n_full);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[hash_table_linear_probe] OK");
    end else begin
      $display("[hash_table_linear_probe] ERROR");
    end
    $finish;
  end

endmodule

>>> hash_table_linear_probe.f
hdl/htlp_pkg.sv
hdl/htlp_ram.sv
hdl/htlp_hash.sv
hdl/hash_table_linear_probe.sv
hdl/htlp_checker.sv
tb/tb_top.sv
